@@ hdl/bsst_pkg.sv @@
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared widths, constants and defaults of the bounded set span tracker.
// ----------------------------------------------------------------------------
package bsst_pkg;

    localparam int VAL_W       = 32;    // held value, signed
    localparam int CNT_W       = 11;    // count and capacity
    localparam int SPAN_W      = 32;    // reported spans
    localparam int GAP_W       = 33;    // exact difference of two values
    localparam int STORE_DEPTH = 1024;  // default store depth

    localparam logic [CNT_W-1:0] CAP_RESET    = CNT_W'(1);
    localparam logic [GAP_W-1:0] GAP_ALL_ONES = '1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

@@ hdl/bsst_if.sv @@
// ----------------------------------------------------------------------------
// bsst_in_if / bsst_out_if
// Valid/ready channels carrying input values and span results.
// ----------------------------------------------------------------------------
interface bsst_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bsst_pkg::VAL_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bsst_out_if;
    logic                                valid;
    logic                                ready;
    logic                                status;
    logic        [bsst_pkg::CNT_W-1:0]   entry_total;
    logic                                span_valid;
    logic        [bsst_pkg::SPAN_W-1:0]  shortest_span;
    logic        [bsst_pkg::SPAN_W-1:0]  longest_span;

    modport source (output valid, output status, output entry_total, output span_valid,
                    output shortest_span, output longest_span, input ready);
    modport sink   (input valid, input status, input entry_total, input span_valid,
                    input shortest_span, input longest_span, output ready);
endinterface

@@ hdl/bsst_ram.sv @@
// ----------------------------------------------------------------------------
// bsst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bsst_alu.sv @@
// ----------------------------------------------------------------------------
// bsst_alu
// Shared 33-bit subtractor: exact difference of two signed 32-bit values.
// ----------------------------------------------------------------------------
module bsst_alu (
    input  logic signed [bsst_pkg::VAL_W-1:0] i_a,
    input  logic signed [bsst_pkg::VAL_W-1:0] i_b,
    output logic        [bsst_pkg::GAP_W-1:0] o_diff
);

    // sign-extend both operands so the difference never wraps
    assign o_diff = {i_a[bsst_pkg::VAL_W-1], i_a} - {i_b[bsst_pkg::VAL_W-1], i_b};

endmodule

@@ hdl/bounded_set_span_tracker_top.sv @@
// ----------------------------------------------------------------------------
// bounded_set_span_tracker_top
// Sorted bounded set with running shortest gap and value range.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    value (s32)
//  o_out     out  valid/ready    status, entry_total, span_valid,
//                                shortest_span, longest_span
//  cfg       in   i_cfg_we       i_cfg_wdata = capacity (u11)
//
//  A rejected request goes from idle straight to the done state, where the
//  result register is loaded. An insert moves each held value greater than
//  the new one up an entry, in a one-entry-per-cycle shift walk through the
//  store RAM, then writes the new value; an insert into an empty store skips
//  the walk. Input ready is high only while the sequencer idles; a waiting
//  result does not block acceptance, it stalls only the next result.
//  Synchronous active-low reset; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module bounded_set_span_tracker_top #(
    parameter int STORE_DEPTH = bsst_pkg::STORE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bsst_pkg::CNT_W-1:0]   i_cfg_wdata,
    bsst_in_if.sink                      i_in,
    bsst_out_if.source                   o_out
);

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_CMP   = 6'b000100,
        S_PLACE = 6'b001000,
        S_SUCC  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // control
    t_state                            r_state,  n_state;
    logic [bsst_pkg::CNT_W-1:0]        r_cap,    n_cap;
    logic [bsst_pkg::CNT_W-1:0]        r_held,   n_held;
    logic [bsst_pkg::CNT_W-1:0]        r_k,      n_k;
    logic                              r_has_pred, n_has_pred;
    logic                              r_has_succ, n_has_succ;
    logic                              r_ov,     n_ov;
    logic signed [bsst_pkg::VAL_W-1:0] r_least,  n_least;
    logic signed [bsst_pkg::VAL_W-1:0] r_great,  n_great;
    logic [bsst_pkg::GAP_W-1:0]        r_gap,    n_gap;
    // payload
    logic signed [bsst_pkg::VAL_W-1:0] r_v,      n_v;
    logic signed [bsst_pkg::VAL_W-1:0] r_pred,   n_pred;
    logic signed [bsst_pkg::VAL_W-1:0] r_succ,   n_succ;
    logic                              r_rej,    n_rej;
    logic                              r_o_status,  n_o_status;
    logic [bsst_pkg::CNT_W-1:0]        r_o_total,   n_o_total;
    logic                              r_o_spanv,   n_o_spanv;
    logic [bsst_pkg::SPAN_W-1:0]       r_o_short,   n_o_short;
    logic [bsst_pkg::SPAN_W-1:0]       r_o_long,    n_o_long;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [AW-1:0]                     ram_raddr;
    logic [bsst_pkg::VAL_W-1:0]        ram_wdata;
    logic signed [bsst_pkg::VAL_W-1:0] ram_rdata;
    logic signed [bsst_pkg::VAL_W-1:0] alu_a;
    logic signed [bsst_pkg::VAL_W-1:0] alu_b;
    logic [bsst_pkg::GAP_W-1:0]        alu_diff;
    logic                              full;
    logic                              span_now;

    bsst_ram #(
        .WIDTH (bsst_pkg::VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bsst_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff)
    );

    assign full = (r_held >= r_cap) || (32'(r_held) >= 32'(STORE_DEPTH));
    assign span_now = r_held >= bsst_pkg::CNT_W'(2);

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.status        = r_o_status;
    assign o_out.entry_total   = r_o_total;
    assign o_out.span_valid    = r_o_spanv;
    assign o_out.shortest_span = r_o_short;
    assign o_out.longest_span  = r_o_long;

    // shared subtractor operands
    always_comb begin
        case (r_state)
            S_PLACE: begin
                alu_a = r_v;
                alu_b = r_pred;
            end
            S_SUCC: begin
                alu_a = r_succ;
                alu_b = r_v;
            end
            default: begin
                alu_a = r_v;
                alu_b = ram_rdata;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cap      = r_cap;
        n_held     = r_held;
        n_k        = r_k;
        n_has_pred = r_has_pred;
        n_has_succ = r_has_succ;
        n_ov       = r_ov;
        n_least    = r_least;
        n_great    = r_great;
        n_gap      = r_gap;
        n_v        = r_v;
        n_pred     = r_pred;
        n_succ     = r_succ;
        n_rej      = r_rej;
        n_o_status = r_o_status;
        n_o_total  = r_o_total;
        n_o_spanv  = r_o_spanv;
        n_o_short  = r_o_short;
        n_o_long   = r_o_long;
        ram_we     = 1'b0;
        ram_waddr  = AW'(r_k);
        ram_wdata  = ram_rdata;
        ram_raddr  = AW'(r_k - bsst_pkg::CNT_W'(1));

        if (i_cfg_we) begin
            n_cap = i_cfg_wdata;
        end
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_v        = i_in.value;
                    n_k        = r_held;
                    n_has_pred = 1'b0;
                    n_has_succ = 1'b0;
                    n_rej      = full;
                    if (full) begin
                        n_state = S_DONE;
                    end else if (r_held == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // negative difference: stored entry is above the new value, shift it up
                if (alu_diff[bsst_pkg::GAP_W-1]) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    ram_raddr  = AW'(r_k - bsst_pkg::CNT_W'(2));
                    n_succ     = ram_rdata;
                    n_has_succ = 1'b1;
                    n_k        = r_k - bsst_pkg::CNT_W'(1);
                    if (r_k == bsst_pkg::CNT_W'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_pred     = ram_rdata;
                    n_has_pred = 1'b1;
                    n_state    = S_PLACE;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_wdata = r_v;
                if (r_has_pred && (alu_diff < r_gap)) begin
                    n_gap = alu_diff;
                end
                if (r_held == '0) begin
                    n_least = r_v;
                    n_great = r_v;
                end else begin
                    if (r_v < r_least) begin
                        n_least = r_v;
                    end
                    if (r_v > r_great) begin
                        n_great = r_v;
                    end
                end
                n_held  = r_held + bsst_pkg::CNT_W'(1);
                n_state = S_SUCC;
            end
            S_SUCC: begin
                if (r_has_succ && (alu_diff < r_gap)) begin
                    n_gap = alu_diff;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_rej ? bsst_pkg::STATUS_FULL : bsst_pkg::STATUS_OK;
                    n_o_total  = r_held;
                    n_o_spanv  = span_now;
                    n_o_short  = span_now ? r_gap[bsst_pkg::SPAN_W-1:0] : '0;
                    n_o_long   = span_now ? bsst_pkg::SPAN_W'(r_great - r_least) : '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cap      <= bsst_pkg::CAP_RESET;
            r_held     <= '0;
            r_k        <= '0;
            r_has_pred <= 1'b0;
            r_has_succ <= 1'b0;
            r_ov       <= 1'b0;
            r_least    <= '0;
            r_great    <= '0;
            r_gap      <= bsst_pkg::GAP_ALL_ONES;
        end else begin
            r_state    <= n_state;
            r_cap      <= n_cap;
            r_held     <= n_held;
            r_k        <= n_k;
            r_has_pred <= n_has_pred;
            r_has_succ <= n_has_succ;
            r_ov       <= n_ov;
            r_least    <= n_least;
            r_great    <= n_great;
            r_gap      <= n_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_pred     <= n_pred;
        r_succ     <= n_succ;
        r_rej      <= n_rej;
        r_o_status <= n_o_status;
        r_o_total  <= n_o_total;
        r_o_spanv  <= n_o_spanv;
        r_o_short  <= n_o_short;
        r_o_long   <= n_o_long;
    end

endmodule

@@ hdl/bsst_checker.sv @@
// ----------------------------------------------------------------------------
// bsst_checker
// Port-level checks of the span tracker, bound to the top level.
// ----------------------------------------------------------------------------
module bsst_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_status,
    input logic [bsst_pkg::CNT_W-1:0]    i_out_total,
    input logic                          i_out_spanv,
    input logic [bsst_pkg::SPAN_W-1:0]   i_out_short,
    input logic [bsst_pkg::SPAN_W-1:0]   i_out_long
);

    // the sequencer leaves idle on every accepted request, so input ready drops
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready high straight after an accepted request");

    a_span_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_spanv == (i_out_total >= bsst_pkg::CNT_W'(2))))
        else $error("span_valid disagrees with entry_total");

    a_no_span_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_spanv) |-> (i_out_short == '0 && i_out_long == '0))
        else $error("spans non-zero without a span");

    // a neighbour gap can never exceed the full range
    a_short_le_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_spanv) |-> (i_out_short <= i_out_long))
        else $error("shortest span above longest span");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_status)
            && $stable(i_out_total) && $stable(i_out_short) && $stable(i_out_long)))
        else $error("stalled result changed");

endmodule

bind bounded_set_span_tracker_top bsst_checker u_bsst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_total  (o_out.entry_total),
    .i_out_spanv  (o_out.span_valid),
    .i_out_short  (o_out.shortest_span),
    .i_out_long   (o_out.longest_span)
);
